/* hdl/i2ctq_pkg.sv */
// Shared types and constants of the I2C transaction queue sequencer.
package i2ctq_pkg;

  localparam int unsigned QueueDepthDefault = 8;
  localparam int unsigned MaxWrite          = 4;
  localparam int unsigned MaxRead           = 2;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_POLL = 2'd1,
    CMD_IRQ  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ACTIVE = 2'd1,
    MODE_WDONE  = 2'd2,
    MODE_RDONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PH_WR_DATA = 3'd0,
    PH_WR_DONE = 3'd1,
    PH_RD_ADDR = 3'd2,
    PH_RD_DATA = 3'd3,
    PH_RD_ACK  = 3'd4,
    PH_RD_STOP = 3'd5,
    PH_RD_DONE = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_START  = 3'd1,
    ACT_RSTART = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_TX     = 3'd4,
    ACT_RCEN   = 3'd5,
    ACT_ACK    = 3'd6
  } action_e;

  typedef struct packed {
    logic [2:0]      tag;
    logic [2:0]      wcount;
    logic [3:0][7:0] wbytes;
    logic [1:0]      rcount;
    logic [7:0]      raddr;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  typedef struct packed {
    action_e     bus_action;
    logic [7:0]  tx_byte;
    logic        done_res;
    logic [2:0]  done_chan;
    logic [15:0] read_word;
    logic        was_read;
    logic        dropped;
    logic        busy_res;
  } result_t;

endpackage

/* hdl/i2ctq_req_if.sv */
// Request channel: one queue command with its transaction fields.
interface i2ctq_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [2:0] chan_tag;
  logic [2:0] write_count;
  logic [7:0] write_byte_0;
  logic [7:0] write_byte_1;
  logic [7:0] write_byte_2;
  logic [7:0] write_byte_3;
  logic [1:0] read_count;
  logic [7:0] read_address;
  logic [7:0] rx_byte;

  modport source (
    output valid, cmd, chan_tag, write_count, write_byte_0, write_byte_1,
           write_byte_2, write_byte_3, read_count, read_address, rx_byte,
    input  ready
  );

  modport sink (
    input  valid, cmd, chan_tag, write_count, write_byte_0, write_byte_1,
           write_byte_2, write_byte_3, read_count, read_address, rx_byte,
    output ready
  );
endinterface

/* hdl/i2ctq_rsp_if.sv */
// Response channel: bus action and retirement report for one request.
interface i2ctq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  bus_action;
  logic [7:0]  tx_byte;
  logic        done_res;
  logic [2:0]  done_chan;
  logic [15:0] read_word;
  logic        was_read;
  logic        dropped;
  logic        busy_res;

  modport source (
    output valid, bus_action, tx_byte, done_res, done_chan, read_word, was_read,
           dropped, busy_res,
    input  ready
  );

  modport sink (
    input  valid, bus_action, tx_byte, done_res, done_chan, read_word, was_read,
           dropped, busy_res,
    output ready
  );
endinterface

/* hdl/i2ctq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module i2ctq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/i2c_transaction_queue_sequencer.sv */
// Top level: I2C master transaction queue and bus phase sequencer.
//
//   channel | modport | carries
//   --------+---------+------------------------------------------------
//   req_i   | sink    | command, transaction fields, received bus byte
//   rsp_o   | source  | bus action, transmit byte, retirement report
//
// Each request is handled in the cycle it is accepted and its response is
// registered, so one request per cycle is taken unless a held response
// stalls it; the head queue entry comes from a registered-read RAM kept on
// the next head position, with a bypass for a write to that same position.
// Reset clears pointers, mode, phase and counters; the queue RAM is not
// cleared. A response held by a stalled sink blocks new requests only while
// it is not being taken.
module i2c_transaction_queue_sequencer #(
  parameter int unsigned QueueDepth = i2ctq_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2ctq_req_if.sink   req_i,
  i2ctq_rsp_if.source rsp_o
);
  import i2ctq_pkg::*;

  localparam int unsigned AddrW = $clog2(QueueDepth);

  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AddrW-1:0] head_nxt, tail_nxt;
  mode_e            mode_q, mode_d;
  phase_e           phase_q, phase_d;
  logic [2:0]       widx_q, widx_d;
  logic [1:0]       ridx_q, ridx_d, ridx_inc;
  logic [15:0]      rbuf_q, rbuf_d;

  logic    out_valid_q;
  result_t out_q, res;
  logic    accept, in_ready;

  logic   we;
  entry_t wr_entry, ram_entry, cur;
  logic   byp_q, byp_d;
  entry_t byp_data_q;

  cmd_e cmd;

  assign in_ready    = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && in_ready;
  assign req_i.ready = in_ready;
  assign cmd         = cmd_e'(req_i.cmd);

  assign head_nxt = (head_q == AddrW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == AddrW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;

  // Saturate counts on entry
  always_comb begin
    wr_entry.tag    = req_i.chan_tag;
    wr_entry.wcount = (req_i.write_count > 3'(MaxWrite)) ? 3'(MaxWrite)
                                                        : req_i.write_count;
    wr_entry.wbytes = {req_i.write_byte_3, req_i.write_byte_2,
                       req_i.write_byte_1, req_i.write_byte_0};
    wr_entry.rcount = (req_i.read_count > 2'(MaxRead)) ? 2'(MaxRead)
                                                      : req_i.read_count;
    wr_entry.raddr  = req_i.read_address;
  end

  i2ctq_ram #(
    .Width (EntryWidth),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_q),
    .wdata_i (wr_entry),
    .raddr_i (head_d),
    .rdata_o (ram_entry)
  );

  // Bypass a write that lands on the entry being read
  assign byp_d = we && (tail_q == head_d);
  assign cur   = byp_q ? byp_data_q : ram_entry;

  assign ridx_inc = (ridx_q < 2'd3) ? ridx_q + 2'd1 : ridx_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    mode_d  = mode_q;
    phase_d = phase_q;
    widx_d  = widx_q;
    ridx_d  = ridx_q;
    rbuf_d  = rbuf_q;
    we      = 1'b0;
    res     = '0;

    if (accept) begin
      unique case (cmd)
        CMD_ENQ: begin
          if (tail_nxt == head_q) begin
            res.dropped = 1'b1;
          end else begin
            we     = 1'b1;
            tail_d = tail_nxt;
          end
        end
        CMD_POLL: begin
          if (mode_q == MODE_IDLE) begin
            if (head_q != tail_q) begin
              mode_d         = MODE_ACTIVE;
              phase_d        = PH_WR_DATA;
              widx_d         = '0;
              ridx_d         = '0;
              rbuf_d         = '0;
              res.bus_action = ACT_START;
            end
          end else if (mode_q == MODE_WDONE || mode_q == MODE_RDONE) begin
            res.done_res  = 1'b1;
            res.done_chan = cur.tag;
            if (mode_q == MODE_RDONE) begin
              res.was_read  = 1'b1;
              res.read_word = rbuf_q;
            end
            head_d = head_nxt;
            mode_d = MODE_IDLE;
          end
        end
        CMD_IRQ: begin
          if (mode_q != MODE_IDLE) begin
            unique case (phase_q)
              PH_WR_DATA: begin
                if (mode_q == MODE_ACTIVE) begin
                  if (widx_q < cur.wcount) begin
                    res.bus_action = ACT_TX;
                    res.tx_byte    = cur.wbytes[widx_q[1:0]];
                    widx_d         = widx_q + 3'd1;
                  end else if (cur.rcount != 2'd0) begin
                    phase_d        = PH_RD_ADDR;
                    res.bus_action = ACT_RSTART;
                  end else begin
                    phase_d        = PH_WR_DONE;
                    res.bus_action = ACT_STOP;
                  end
                end
              end
              PH_WR_DONE: begin
                if (mode_q == MODE_ACTIVE) begin
                  mode_d = MODE_WDONE;
                end
              end
              PH_RD_ADDR: begin
                res.bus_action = ACT_TX;
                res.tx_byte    = cur.raddr;
                ridx_d         = '0;
                phase_d        = PH_RD_DATA;
              end
              PH_RD_DATA: begin
                res.bus_action = ACT_RCEN;
                phase_d        = PH_RD_ACK;
              end
              PH_RD_ACK: begin
                res.bus_action = ACT_ACK;
                // First byte is the high byte of the read word
                if (ridx_q == 2'd0) begin
                  rbuf_d[15:8] = req_i.rx_byte;
                end else if (ridx_q == 2'd1) begin
                  rbuf_d[7:0] = req_i.rx_byte;
                end
                ridx_d  = ridx_inc;
                phase_d = (ridx_inc < cur.rcount) ? PH_RD_DATA : PH_RD_STOP;
              end
              PH_RD_STOP: begin
                res.bus_action = ACT_STOP;
                phase_d        = PH_RD_DONE;
              end
              PH_RD_DONE: begin
                if (mode_q == MODE_ACTIVE) begin
                  mode_d = MODE_RDONE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    res.busy_res = (mode_d != MODE_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      mode_q      <= MODE_IDLE;
      phase_q     <= PH_WR_DATA;
      widx_q      <= '0;
      ridx_q      <= '0;
      rbuf_q      <= '0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      mode_q  <= mode_d;
      phase_q <= phase_d;
      widx_q  <= widx_d;
      ridx_q  <= ridx_d;
      rbuf_q  <= rbuf_d;
      byp_q   <= byp_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      byp_data_q <= wr_entry;
    end
    if (accept) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.bus_action = out_q.bus_action;
  assign rsp_o.tx_byte    = out_q.tx_byte;
  assign rsp_o.done_res   = out_q.done_res;
  assign rsp_o.done_chan  = out_q.done_chan;
  assign rsp_o.read_word  = out_q.read_word;
  assign rsp_o.was_read   = out_q.was_read;
  assign rsp_o.dropped    = out_q.dropped;
  assign rsp_o.busy_res   = out_q.busy_res;

endmodule

/* dv/tb_top.sv */
// Testbench for the I2C transaction queue sequencer: random requests checked against a predictor.
module tb_top;
  import i2ctq_pkg::*;

  localparam int unsigned QueueDepth  = QueueDepthDefault;
  localparam int unsigned NumRequests = 1800;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 20;

  typedef struct {
    cmd_e            cmd;
    logic [2:0]      chan_tag;
    logic [2:0]      write_count;
    logic [3:0][7:0] wbytes;
    logic [1:0]      read_count;
    logic [7:0]      read_address;
    logic [7:0]      rx_byte;
  } queue_req_t;

  logic clk_i;
  logic rst_ni;

  i2ctq_req_if req_if ();
  i2ctq_rsp_if rsp_if ();

  i2c_transaction_queue_sequencer #(
    .QueueDepth(QueueDepth)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Sequencer shadow state
  entry_t      txn_ram [QueueDepth];
  int unsigned head_q;
  int unsigned tail_q;
  mode_e       mode_q;
  phase_e      phase_q;
  logic [2:0]  widx_q;
  logic [1:0]  ridx_q;
  logic [15:0] rbuf_q;

  queue_req_t  cmd_backlog [$];
  result_t     predicted_rsp [$];

  int unsigned req_total;
  int unsigned req_accepted;
  int unsigned req_loaded;
  int unsigned rsp_taken;
  int unsigned req_gap;
  int unsigned rsp_hold;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  bit          req_fired;
  bit          rsp_fired;
  bit          req_calm;
  bit          rsp_calm;
  queue_req_t  nxt_req;
  queue_req_t  seen_req;
  result_t     got_rsp;

  function automatic result_t sequence_step(queue_req_t r);
    result_t     res;
    entry_t      cur;
    entry_t      ent;
    int unsigned nxt;
    res            = '0;
    res.bus_action = ACT_NONE;
    cur            = txn_ram[head_q];
    case (r.cmd)
      CMD_ENQ: begin
        nxt = (tail_q + 1) % QueueDepth;
        if (nxt == head_q) begin
          res.dropped = 1'b1;
        end else begin
          ent.tag    = r.chan_tag;
          ent.wcount = (r.write_count > MaxWrite) ? 3'(MaxWrite) : r.write_count;
          ent.wbytes = r.wbytes;
          ent.rcount = (r.read_count > MaxRead) ? 2'(MaxRead) : r.read_count;
          ent.raddr  = r.read_address;
          txn_ram[tail_q] = ent;
          tail_q          = nxt;
        end
      end
      CMD_POLL: begin
        if (mode_q == MODE_IDLE) begin
          if (head_q != tail_q) begin
            mode_q         = MODE_ACTIVE;
            phase_q        = PH_WR_DATA;
            widx_q         = '0;
            ridx_q         = '0;
            rbuf_q         = '0;
            res.bus_action = ACT_START;
          end
        end else if (mode_q == MODE_WDONE || mode_q == MODE_RDONE) begin
          res.done_res  = 1'b1;
          res.done_chan = cur.tag;
          if (mode_q == MODE_RDONE) begin
            res.was_read  = 1'b1;
            res.read_word = rbuf_q;
          end
          head_q = (head_q + 1) % QueueDepth;
          mode_q = MODE_IDLE;
        end
      end
      CMD_IRQ: begin
        if (mode_q != MODE_IDLE) begin
          case (phase_q)
            PH_WR_DATA: begin
              if (mode_q == MODE_ACTIVE) begin
                if (widx_q < cur.wcount) begin
                  res.bus_action = ACT_TX;
                  res.tx_byte    = cur.wbytes[widx_q[1:0]];
                  widx_q         = widx_q + 3'd1;
                end else if (cur.rcount != 0) begin
                  phase_q        = PH_RD_ADDR;
                  res.bus_action = ACT_RSTART;
                end else begin
                  phase_q        = PH_WR_DONE;
                  res.bus_action = ACT_STOP;
                end
              end
            end
            PH_WR_DONE: begin
              if (mode_q == MODE_ACTIVE) mode_q = MODE_WDONE;
            end
            PH_RD_ADDR: begin
              res.bus_action = ACT_TX;
              res.tx_byte    = cur.raddr;
              ridx_q         = '0;
              phase_q        = PH_RD_DATA;
            end
            PH_RD_DATA: begin
              res.bus_action = ACT_RCEN;
              phase_q        = PH_RD_ACK;
            end
            PH_RD_ACK: begin
              res.bus_action = ACT_ACK;
              // first byte lands in the upper half, later bytes beyond two are lost
              if (ridx_q == 2'd0) rbuf_q[15:8] = r.rx_byte;
              else if (ridx_q == 2'd1) rbuf_q[7:0] = r.rx_byte;
              if (ridx_q < 2'd3) ridx_q = ridx_q + 2'd1;
              phase_q = (ridx_q < cur.rcount) ? PH_RD_DATA : PH_RD_STOP;
            end
            PH_RD_STOP: begin
              res.bus_action = ACT_STOP;
              phase_q        = PH_RD_DONE;
            end
            PH_RD_DONE: begin
              if (mode_q == MODE_ACTIVE) mode_q = MODE_RDONE;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    res.busy_res = (mode_q != MODE_IDLE);
    return res;
  endfunction

  function automatic queue_req_t make_request(cmd_e kind);
    queue_req_t r;
    r.cmd          = kind;
    r.chan_tag     = 3'($urandom_range(0, 7));
    r.write_count  = 3'($urandom_range(0, 7));
    r.wbytes       = $urandom;
    r.read_count   = 2'($urandom_range(0, 3));
    r.read_address = 8'($urandom);
    r.rx_byte      = 8'($urandom);
    return r;
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t: %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      note_mismatch($sformatf("response %0d %s: expected 0x%0h, got 0x%0h",
                              rsp_taken, name, exp_v, act_v));
    end
  endtask

  task automatic check_response(result_t act);
    result_t exp;
    if (predicted_rsp.size() == 0) begin
      note_mismatch($sformatf("unexpected response %p", act));
    end else begin
      exp = predicted_rsp.pop_front();
      compare_field("bus_action", exp.bus_action, act.bus_action);
      compare_field("tx_byte", exp.tx_byte, act.tx_byte);
      compare_field("done_res", exp.done_res, act.done_res);
      compare_field("done_chan", exp.done_chan, act.done_chan);
      compare_field("read_word", exp.read_word, act.read_word);
      compare_field("was_read", exp.was_read, act.was_read);
      compare_field("dropped", exp.dropped, act.dropped);
      compare_field("busy_res", exp.busy_res, act.busy_res);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Request driver: wait out the drawn gap, then hold each request until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!req_if.valid || req_fired)) begin
      if (req_gap != 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        nxt_req = cmd_backlog.pop_front();
        req_if.cmd          <= nxt_req.cmd;
        req_if.chan_tag     <= nxt_req.chan_tag;
        req_if.write_count  <= nxt_req.write_count;
        req_if.write_byte_0 <= nxt_req.wbytes[0];
        req_if.write_byte_1 <= nxt_req.wbytes[1];
        req_if.write_byte_2 <= nxt_req.wbytes[2];
        req_if.write_byte_3 <= nxt_req.wbytes[3];
        req_if.read_count   <= nxt_req.read_count;
        req_if.read_address <= nxt_req.read_address;
        req_if.rx_byte      <= nxt_req.rx_byte;
        req_if.valid        <= 1'b1;
        req_loaded++;
        if (req_loaded % 50 == 0) req_calm = ($urandom_range(0, 3) == 0);
        req_gap = draw_wait(req_calm);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response sink: hold ready low for a drawn wait after each response
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_fired) begin
        rsp_taken++;
        if (rsp_taken % 50 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
        rsp_hold = draw_wait(rsp_calm);
      end
      if (rsp_hold != 0) begin
        rsp_hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Monitor and watchdog
  always @(posedge clk_i) begin
    req_fired = rst_ni && req_if.valid && req_if.ready;
    rsp_fired = rst_ni && rsp_if.valid && rsp_if.ready;
    if (rsp_fired) begin
      got_rsp.bus_action = action_e'(rsp_if.bus_action);
      got_rsp.tx_byte    = rsp_if.tx_byte;
      got_rsp.done_res   = rsp_if.done_res;
      got_rsp.done_chan  = rsp_if.done_chan;
      got_rsp.read_word  = rsp_if.read_word;
      got_rsp.was_read   = rsp_if.was_read;
      got_rsp.dropped    = rsp_if.dropped;
      got_rsp.busy_res   = rsp_if.busy_res;
      check_response(got_rsp);
    end
    if (req_fired) begin
      seen_req.cmd          = cmd_e'(req_if.cmd);
      seen_req.chan_tag     = req_if.chan_tag;
      seen_req.write_count  = req_if.write_count;
      seen_req.wbytes       = {req_if.write_byte_3, req_if.write_byte_2,
                               req_if.write_byte_1, req_if.write_byte_0};
      seen_req.read_count   = req_if.read_count;
      seen_req.read_address = req_if.read_address;
      seen_req.rx_byte      = req_if.rx_byte;
      predicted_rsp.push_back(sequence_step(seen_req));
      req_accepted++;
    end
    if (!rst_ni || req_fired || rsp_fired) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    queue_req_t r;
    int unsigned k;
    int unsigned pick;
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.cmd          = CMD_NOP;
    req_if.chan_tag     = '0;
    req_if.write_count  = '0;
    req_if.write_byte_0 = '0;
    req_if.write_byte_1 = '0;
    req_if.write_byte_2 = '0;
    req_if.write_byte_3 = '0;
    req_if.read_count   = '0;
    req_if.read_address = '0;
    req_if.rx_byte      = '0;
    rsp_if.ready        = 1'b0;
    head_q  = 0;
    tail_q  = 0;
    mode_q  = MODE_IDLE;
    phase_q = PH_WR_DATA;
    widx_q  = '0;
    ridx_q  = '0;
    rbuf_q  = '0;
    req_calm = 1'b0;
    rsp_calm = 1'b0;

    // Empty queue: poll, interrupt and no-op do nothing and report not busy
    cmd_backlog.push_back(make_request(CMD_POLL));
    cmd_backlog.push_back(make_request(CMD_IRQ));
    cmd_backlog.push_back(make_request(CMD_NOP));
    // Fill to capacity, the last enqueue is dropped
    for (k = 0; k < QueueDepth; k++) begin
      r = make_request(CMD_ENQ);
      case (k)
        0: begin
          r.write_count = 3'd0;
          r.read_count  = 2'd0;
        end
        1: begin
          r.chan_tag     = 3'd7;
          r.write_count  = 3'd4;
          r.read_count   = 2'd2;
          r.wbytes       = 32'hFF00_FF00;
          r.read_address = 8'hFF;
        end
        2: begin
          // saturating counts
          r.chan_tag     = 3'd0;
          r.write_count  = 3'd7;
          r.read_count   = 2'd3;
          r.wbytes       = 32'h00FF_00FF;
          r.read_address = 8'h00;
        end
        3: begin
          r.write_count = 3'd1;
          r.read_count  = 2'd1;
        end
        default: ;
      endcase
      cmd_backlog.push_back(r);
    end
    // Write-only transaction with no bytes: start, poll while active, stop,
    // completion, repeated completion, retire
    cmd_backlog.push_back(make_request(CMD_POLL));
    cmd_backlog.push_back(make_request(CMD_POLL));
    repeat (3) cmd_backlog.push_back(make_request(CMD_IRQ));
    cmd_backlog.push_back(make_request(CMD_POLL));

    // Mostly whole transactions with a sprinkling of noise, plus enqueue bursts
    while (cmd_backlog.size() < NumRequests) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        repeat ($urandom_range(1, 9)) cmd_backlog.push_back(make_request(CMD_ENQ));
      end else if (pick < 17) begin
        cmd_backlog.push_back(make_request(CMD_POLL));
        repeat ($urandom_range(2, 16)) begin
          if ($urandom_range(0, 15) == 0)
            cmd_backlog.push_back(make_request(cmd_e'($urandom_range(0, 3))));
          else
            cmd_backlog.push_back(make_request(CMD_IRQ));
        end
        cmd_backlog.push_back(make_request(CMD_POLL));
      end else begin
        repeat ($urandom_range(1, 4))
          cmd_backlog.push_back(make_request(cmd_e'($urandom_range(0, 3))));
      end
    end
    req_total = cmd_backlog.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i);
    while (req_accepted < req_total || predicted_rsp.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && predicted_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
